// File: rtl/core/hbepa_pkg.sv
// Shared constants, codes, payload types and pipeline structs of the histogram bin ALU.
package hbepa_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// Double word for products, numerator width for the widest quotient.
	localparam int DW     = 2 * WORD_BITS;
	localparam int NUM_W  = 2 * WORD_BITS + FRAC_BITS;
	localparam int SREM_W = WORD_BITS + 2;

	localparam logic [WORD_BITS-1:0] ERR_MAX     = {WORD_BITS{1'b1}};
	localparam logic [WORD_BITS-1:0] VAL_POS_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] VAL_NEG_MAG = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic [WORD_BITS-1:0] SCALE_ONE   =
		{{(WORD_BITS-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [DW-1:0]        DEN_ONE     = {{(DW-1){1'b0}}, 1'b1};

	localparam logic MODE_COUNTS = 1'b0;
	localparam logic MODE_FREQ   = 1'b1;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [2:0] {
		OP_SCALE = 3'd0,
		OP_DIVF  = 3'd1,
		OP_ADD   = 3'd2,
		OP_SUB   = 3'd3,
		OP_MUL   = 3'd4,
		OP_DIV   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MODE    = 2'd1,
		ST_DIVZERO = 2'd2,
		ST_SAT     = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE  = 2'd0,
		CFG_MODE_A = 2'd1,
		CFG_MODE_B = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		op_t                         op;
		logic signed [WORD_BITS-1:0] value_a;
		logic        [WORD_BITS-1:0] error_a;
		logic signed [WORD_BITS-1:0] value_b;
		logic        [WORD_BITS-1:0] error_b;
	} item_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] value_out;
		logic        [WORD_BITS-1:0] error_out;
		logic                        mode_out;
		status_t                     status;
	} result_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] scale_factor;
		logic                 mode_a;
		logic                 mode_b;
	} cfg_t;

	// One lane of the restoring divider chain.
	typedef struct packed {
		logic                 ovf;
		logic [DW-1:0]        den;
		logic [DW-1:0]        rem;
		logic [WORD_BITS-1:0] num;
		logic [WORD_BITS-1:0] quo;
	} lane_t;

	typedef struct packed {
		logic mode;
		logic bad;
		logic dz;
		logic neg;
	} dside_t;

	// Digit-by-digit square root state.
	typedef struct packed {
		logic [SREM_W-1:0]    rem;
		logic [WORD_BITS-1:0] root;
		logic [DW-1:0]        x;
	} sqrt_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] vout;
		logic                        sat;
		logic                        xovf;
		logic                        mode;
		logic                        bad;
		logic                        dz;
	} sside_t;

endpackage

// File: rtl/core/hbepa_front.sv
// Front end: operation decode, magnitudes, products and divider lane setup.
module hbepa_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_in,
	input  hbepa_pkg::item_t      item,
	input  hbepa_pkg::cfg_t       cfg,
	output logic                  vld_out,
	output hbepa_pkg::lane_t [2:0] lanes,
	output hbepa_pkg::dside_t     side
);
	import hbepa_pkg::*;

	function automatic lane_t lane_init(input logic [NUM_W-1:0] n, input logic [DW-1:0] d);
		lane_t l;
		l.den = d;
		l.rem = DW'(n[NUM_W-1:WORD_BITS]);
		l.ovf = DW'(n[NUM_W-1:WORD_BITS]) >= d;
		l.num = n[WORD_BITS-1:0];
		l.quo = '0;
		return l;
	endfunction

	// Stage 1: decode and magnitudes.
	logic [WORD_BITS-1:0] ma_c, mb_c;
	logic signed [WORD_BITS:0] sa_c, sb_c, sum_c;
	logic bad_c, dz_c, mode_c;

	logic vld_s1, vld_s2, vld_s3;
	op_t op_s1, op_s2;
	logic mode_s1, bad_s1, dz_s1, na_s1, nab_s1;
	logic [WORD_BITS-1:0] ma_s1, mb_s1, ea_s1, eb_s1;
	logic signed [WORD_BITS:0] sum_s1;

	assign ma_c = item.value_a[WORD_BITS-1] ? (~$unsigned(item.value_a) + 1'b1)
		: $unsigned(item.value_a);
	assign mb_c = item.value_b[WORD_BITS-1] ? (~$unsigned(item.value_b) + 1'b1)
		: $unsigned(item.value_b);
	assign sa_c = {item.value_a[WORD_BITS-1], item.value_a};
	assign sb_c = {item.value_b[WORD_BITS-1], item.value_b};
	assign sum_c = (item.op == OP_SUB) ? (sa_c - sb_c) : (sa_c + sb_c);

	always_comb begin
		bad_c  = 1'b0;
		dz_c   = 1'b0;
		mode_c = cfg.mode_a;
		unique case (item.op) inside
			OP_SCALE: begin
			end
			OP_DIVF: begin
				dz_c = (cfg.scale_factor == '0);
			end
			OP_ADD, OP_SUB: begin
				bad_c = (cfg.mode_a != cfg.mode_b);
			end
			OP_MUL: begin
				bad_c  = (cfg.mode_a == MODE_COUNTS) && (cfg.mode_b == MODE_COUNTS);
				mode_c = (cfg.mode_b == MODE_COUNTS) ? MODE_COUNTS : cfg.mode_a;
			end
			OP_DIV: begin
				bad_c  = (cfg.mode_a == MODE_FREQ) && (cfg.mode_b == MODE_COUNTS);
				mode_c = (cfg.mode_a == cfg.mode_b) ? MODE_FREQ : cfg.mode_a;
				dz_c   = (item.value_b == '0);
			end
			default: begin
				bad_c = 1'b1;
			end
		endcase
		if (bad_c) begin
			mode_c = cfg.mode_a;
			dz_c   = 1'b0;
		end
	end

	// Stage 2: three shared multipliers with operands chosen by the operation.
	logic [WORD_BITS-1:0] x0_c, y0_c, y1_c;
	logic [DW-1:0] m0_c, m1_c, m2_c;
	logic neg_c2;
	logic [WORD_BITS:0] smag_c;

	logic mode_s2, bad_s2, dz_s2, neg_s2;
	logic [DW-1:0] m0_s2, m1_s2, m2_s2;
	logic [WORD_BITS:0] smag_s2;
	logic [WORD_BITS-1:0] ma_s2, mb_s2, ea_s2, eb_s2;

	assign x0_c = (op_s1 == OP_DIV) ? mb_s1 : ma_s1;
	assign y0_c = ((op_s1 == OP_MUL) || (op_s1 == OP_DIV)) ? mb_s1 : cfg.scale_factor;
	assign y1_c = (op_s1 == OP_MUL) ? mb_s1 : cfg.scale_factor;
	assign m0_c = x0_c * y0_c;
	assign m1_c = ea_s1 * y1_c;
	assign m2_c = eb_s1 * ma_s1;
	assign smag_c = sum_s1[WORD_BITS] ? (~$unsigned(sum_s1) + 1'b1) : $unsigned(sum_s1);

	always_comb begin
		case (op_s1) inside
			OP_ADD, OP_SUB: neg_c2 = sum_s1[WORD_BITS];
			OP_MUL, OP_DIV: neg_c2 = nab_s1;
			default:        neg_c2 = na_s1;
		endcase
	end

	// Stage 3: every operation becomes three divisions; a divisor of one passes a
	// value through and flags whether it exceeds the word.
	lane_t [2:0] lanes_c;
	logic [NUM_W-1:0] m0_hi, m1_hi, m2_hi, ma_sh, ea_sh, m2_sh;
	logic [DW-1:0] sf_d, mb_d;

	lane_t [2:0] lanes_s3;
	dside_t side_s3;

	assign m0_hi = NUM_W'(m0_s2[DW-1:FRAC_BITS]);
	assign m1_hi = NUM_W'(m1_s2[DW-1:FRAC_BITS]);
	assign m2_hi = NUM_W'(m2_s2[DW-1:FRAC_BITS]);
	assign ma_sh = NUM_W'({ma_s2, {FRAC_BITS{1'b0}}});
	assign ea_sh = NUM_W'({ea_s2, {FRAC_BITS{1'b0}}});
	assign m2_sh = {m2_s2, {FRAC_BITS{1'b0}}};
	assign sf_d  = DW'(cfg.scale_factor);
	assign mb_d  = DW'(mb_s2);

	always_comb begin
		lanes_c[0] = lane_init('0, DEN_ONE);
		lanes_c[1] = lane_init('0, DEN_ONE);
		lanes_c[2] = lane_init('0, DEN_ONE);
		case (op_s2) inside
			OP_SCALE: begin
				lanes_c[0] = lane_init(m0_hi, DEN_ONE);
				lanes_c[1] = lane_init(m1_hi, DEN_ONE);
			end
			OP_DIVF: begin
				lanes_c[0] = lane_init(ma_sh, sf_d);
				lanes_c[1] = lane_init(ea_sh, sf_d);
			end
			OP_ADD, OP_SUB: begin
				lanes_c[0] = lane_init(NUM_W'(smag_s2), DEN_ONE);
				lanes_c[1] = lane_init(NUM_W'(ea_s2), DEN_ONE);
				lanes_c[2] = lane_init(NUM_W'(eb_s2), DEN_ONE);
			end
			OP_MUL: begin
				lanes_c[0] = lane_init(m0_hi, DEN_ONE);
				lanes_c[1] = lane_init(m1_hi, DEN_ONE);
				lanes_c[2] = lane_init(m2_hi, DEN_ONE);
			end
			OP_DIV: begin
				lanes_c[0] = lane_init(ma_sh, mb_d);
				lanes_c[1] = lane_init(ea_sh, mb_d);
				lanes_c[2] = lane_init(m2_sh, m0_s2);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= item.op;
			mode_s1 <= mode_c;
			bad_s1  <= bad_c;
			dz_s1   <= dz_c;
			na_s1   <= item.value_a[WORD_BITS-1];
			nab_s1  <= item.value_a[WORD_BITS-1] ^ item.value_b[WORD_BITS-1];
			ma_s1   <= ma_c;
			mb_s1   <= mb_c;
			ea_s1   <= item.error_a;
			eb_s1   <= item.error_b;
			sum_s1  <= sum_c;

			op_s2   <= op_s1;
			mode_s2 <= mode_s1;
			bad_s2  <= bad_s1;
			dz_s2   <= dz_s1;
			neg_s2  <= neg_c2;
			m0_s2   <= m0_c;
			m1_s2   <= m1_c;
			m2_s2   <= m2_c;
			smag_s2 <= smag_c;
			ma_s2   <= ma_s1;
			mb_s2   <= mb_s1;
			ea_s2   <= ea_s1;
			eb_s2   <= eb_s1;

			lanes_s3     <= lanes_c;
			side_s3.mode <= mode_s2;
			side_s3.bad  <= bad_s2;
			side_s3.dz   <= dz_s2;
			side_s3.neg  <= neg_s2;
		end
	end

	assign vld_out = vld_s3;
	assign lanes   = lanes_s3;
	assign side    = side_s3;

endmodule

// File: rtl/core/hbepa_div_cell.sv
// One restoring-division cell: one quotient bit for each of three lanes.
module hbepa_div_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vld_in,
	input  hbepa_pkg::lane_t [2:0] lanes_in,
	input  hbepa_pkg::dside_t      side_in,
	output logic                   vld_out,
	output hbepa_pkg::lane_t [2:0] lanes_out,
	output hbepa_pkg::dside_t      side_out
);
	import hbepa_pkg::*;

	lane_t [2:0] nxt_c;
	logic vld_q;
	lane_t [2:0] lanes_q;
	dside_t side_q;

	always_comb begin
		logic [DW:0] t;
		logic [DW:0] diff;
		logic ge;
		for (int i = 0; i < 3; i++) begin
			t    = {lanes_in[i].rem, lanes_in[i].num[WORD_BITS-1]};
			diff = t - {1'b0, lanes_in[i].den};
			ge   = (t >= {1'b0, lanes_in[i].den});
			nxt_c[i].ovf = lanes_in[i].ovf;
			nxt_c[i].den = lanes_in[i].den;
			nxt_c[i].rem = ge ? diff[DW-1:0] : t[DW-1:0];
			nxt_c[i].num = {lanes_in[i].num[WORD_BITS-2:0], 1'b0};
			nxt_c[i].quo = {lanes_in[i].quo[WORD_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lanes_q <= nxt_c;
			side_q  <= side_in;
		end
	end

	assign vld_out   = vld_q;
	assign lanes_out = lanes_q;
	assign side_out  = side_q;

endmodule

// File: rtl/core/hbepa_mid.sv
// Middle stages: value clamp, squares of the error terms and square-root setup.
module hbepa_mid (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vld_in,
	input  hbepa_pkg::lane_t [2:0] lanes_in,
	input  hbepa_pkg::dside_t      side_in,
	output logic                   vld_out,
	output hbepa_pkg::sqrt_t       sq_out,
	output hbepa_pkg::sside_t      side_out
);
	import hbepa_pkg::*;

	logic [WORD_BITS-1:0] t1_c, t2_c, vq_c;
	logic over_c;
	logic [WORD_BITS-1:0] v_c;

	logic vld_s1, vld_s2;
	logic [DW-1:0] sq1_s1, sq2_s1;
	logic [WORD_BITS-1:0] v_s1;
	logic sat_s1, mode_s1, bad_s1, dz_s1;
	logic [DW:0] x_c;
	sqrt_t sq_s2;
	sside_t side_s2;

	assign t1_c = lanes_in[1].ovf ? ERR_MAX : lanes_in[1].quo;
	assign t2_c = lanes_in[2].ovf ? ERR_MAX : lanes_in[2].quo;
	assign vq_c = lanes_in[0].quo;

	always_comb begin
		if (side_in.neg) begin
			over_c = lanes_in[0].ovf || (vq_c > VAL_NEG_MAG);
			v_c    = over_c ? VAL_NEG_MAG : (~vq_c + 1'b1);
		end else begin
			over_c = lanes_in[0].ovf || (vq_c > VAL_POS_MAX);
			v_c    = over_c ? VAL_POS_MAX : vq_c;
		end
	end

	assign x_c = {1'b0, sq1_s1} + {1'b0, sq2_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq1_s1  <= t1_c * t1_c;
			sq2_s1  <= t2_c * t2_c;
			v_s1    <= v_c;
			sat_s1  <= over_c | lanes_in[1].ovf | lanes_in[2].ovf;
			mode_s1 <= side_in.mode;
			bad_s1  <= side_in.bad;
			dz_s1   <= side_in.dz;

			sq_s2.rem     <= '0;
			sq_s2.root    <= '0;
			sq_s2.x       <= x_c[DW-1:0];
			side_s2.vout  <= v_s1;
			side_s2.sat   <= sat_s1;
			side_s2.xovf  <= x_c[DW];
			side_s2.mode  <= mode_s1;
			side_s2.bad   <= bad_s1;
			side_s2.dz    <= dz_s1;
		end
	end

	assign vld_out  = vld_s2;
	assign sq_out   = sq_s2;
	assign side_out = side_s2;

endmodule

// File: rtl/core/hbepa_sqrt_cell.sv
// One square-root cell: settles one root bit from two radicand bits.
module hbepa_sqrt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  hbepa_pkg::sqrt_t  sq_in,
	input  hbepa_pkg::sside_t side_in,
	output logic              vld_out,
	output hbepa_pkg::sqrt_t  sq_out,
	output hbepa_pkg::sside_t side_out
);
	import hbepa_pkg::*;

	logic [SREM_W+1:0] t_c, trial_c, diff_c;
	logic ge_c;
	sqrt_t nxt_c;
	logic vld_q;
	sqrt_t sq_q;
	sside_t side_q;

	assign t_c     = {sq_in.rem, sq_in.x[DW-1:DW-2]};
	assign trial_c = {2'b00, sq_in.root, 2'b01};
	assign diff_c  = t_c - trial_c;
	assign ge_c    = (t_c >= trial_c);

	assign nxt_c.rem  = ge_c ? diff_c[SREM_W-1:0] : t_c[SREM_W-1:0];
	assign nxt_c.root = {sq_in.root[WORD_BITS-2:0], ge_c};
	assign nxt_c.x    = {sq_in.x[DW-3:0], 2'b00};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_q   <= nxt_c;
			side_q <= side_in;
		end
	end

	assign vld_out  = vld_q;
	assign sq_out   = sq_q;
	assign side_out = side_q;

endmodule

// File: rtl/core/histogram_bin_error_propagation_alu_top.sv
// Top level of the histogram bin ALU with uncertainty propagation.
//
// Each transaction on the item channel carries one bin pair (values and
// uncertainties of two histograms, Q16.16) and an operation code; the block
// returns one result transaction with the value, the propagated uncertainty,
// the resulting y mode and a status. The block takes one transaction per
// clock and holds up to 70 in flight. On its way an item passes three front
// stages (decode, products, divider setup), a chain of 32 divider cells that
// each settle one quotient bit, two stages that square the error terms, a
// chain of 32 square-root cells that each settle one root bit, and the
// output register. Only back pressure on the result channel slows the block
// down; while a result waits, an empty slot at the end of the pipeline still
// lets a new item in. Configuration writes are taken at any cycle and must
// only be made while the block is idle.
module histogram_bin_error_propagation_alu_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  hbepa_pkg::item_t                      item,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output hbepa_pkg::result_t                    result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [hbepa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hbepa_pkg::WORD_BITS-1:0]       cfg_data
);
	import hbepa_pkg::*;

	// Configuration registers. Writes never stall.
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_factor <= SCALE_ONE;
			cfg_q.mode_a       <= MODE_COUNTS;
			cfg_q.mode_b       <= MODE_COUNTS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SCALE:  cfg_q.scale_factor <= cfg_data;
				CFG_MODE_A: cfg_q.mode_a       <= cfg_data[0];
				CFG_MODE_B: cfg_q.mode_b       <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// The whole pipeline moves as one. It advances whenever the output register
	// can take what leaves the last cell, or when that last cell is empty.
	logic adv;
	logic tail_vld;
	logic out_load;
	logic result_valid_q;
	result_t result_q;

	assign adv        = !tail_vld || !result_valid_q || result_ready;
	assign item_ready = adv;
	assign out_load   = !result_valid_q || result_ready;

	// Front end feeds the divider chain. Every operation is expressed as three
	// divisions; pass-through values use a divisor of one.
	logic   div_vld   [WORD_BITS+1];
	lane_t [2:0] div_lanes [WORD_BITS+1];
	dside_t div_side  [WORD_BITS+1];

	hbepa_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.vld_in  (item_valid),
		.item    (item),
		.cfg     (cfg_q),
		.vld_out (div_vld[0]),
		.lanes   (div_lanes[0]),
		.side    (div_side[0])
	);

	for (genvar g = 0; g < WORD_BITS; g++) begin : g_div
		hbepa_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.vld_in    (div_vld[g]),
			.lanes_in  (div_lanes[g]),
			.side_in   (div_side[g]),
			.vld_out   (div_vld[g+1]),
			.lanes_out (div_lanes[g+1]),
			.side_out  (div_side[g+1])
		);
	end

	// Quotients become the value and the two error terms; the error terms are
	// squared and summed for the square-root chain.
	logic   sq_vld  [WORD_BITS+1];
	sqrt_t  sq_st   [WORD_BITS+1];
	sside_t sq_side [WORD_BITS+1];

	hbepa_mid u_mid (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (div_vld[WORD_BITS]),
		.lanes_in (div_lanes[WORD_BITS]),
		.side_in  (div_side[WORD_BITS]),
		.vld_out  (sq_vld[0]),
		.sq_out   (sq_st[0]),
		.side_out (sq_side[0])
	);

	for (genvar g = 0; g < WORD_BITS; g++) begin : g_sqrt
		hbepa_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (adv),
			.vld_in   (sq_vld[g]),
			.sq_in    (sq_st[g]),
			.side_in  (sq_side[g]),
			.vld_out  (sq_vld[g+1]),
			.sq_out   (sq_st[g+1]),
			.side_out (sq_side[g+1])
		);
	end

	assign tail_vld = sq_vld[WORD_BITS];

	// Final result. An invalid mode combination wins over a zero divisor, which
	// wins over saturation; the first two force value and uncertainty to zero.
	result_t res_c;
	sside_t  tail_side;

	assign tail_side = sq_side[WORD_BITS];

	always_comb begin
		res_c.mode_out = tail_side.mode;
		if (tail_side.bad) begin
			res_c.value_out = '0;
			res_c.error_out = '0;
			res_c.status    = ST_MODE;
		end else if (tail_side.dz) begin
			res_c.value_out = '0;
			res_c.error_out = '0;
			res_c.status    = ST_DIVZERO;
		end else begin
			res_c.value_out = tail_side.vout;
			res_c.error_out = tail_side.xovf ? ERR_MAX : sq_st[WORD_BITS].root;
			res_c.status    = (tail_side.sat || tail_side.xovf) ? ST_SAT : ST_OK;
		end
	end

	// Output register: holds a result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= tail_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q <= res_c;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: rtl/core/hbepa_checker.sv
// Port-level checks of the histogram bin ALU and their attachment to the top level.
module hbepa_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input logic                result_valid,
	input logic                result_ready,
	input hbepa_pkg::result_t  result
);
	import hbepa_pkg::*;

	// A stalled result transaction stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// Mode errors and zero divisors carry a zero value and uncertainty.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_MODE || result.status == ST_DIVZERO)
		|-> result.value_out == '0 && result.error_out == '0)
		else $error("error result with nonzero payload");

	// With the output register empty, the pipeline never refuses an item.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("item refused while output register empty");

	// An item refused in one cycle means a result was waiting and not taken.
	a_refuse_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |-> result_valid && !result_ready)
		else $error("item refused without output back pressure");

endmodule

bind histogram_bin_error_propagation_alu_top hbepa_checker u_hbepa_checker (.*);

// File: sim/tb_histogram_bin_error_propagation_alu_top.sv
// Self-checking testbench for the histogram bin ALU with uncertainty propagation.
`timescale 1ns / 100ps

module tb_histogram_bin_error_propagation_alu_top;
	import hbepa_pkg::*;

	localparam int DRAIN_CYCLES = 100;
	localparam int STALL_LIMIT  = 20000;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_ready;
	item_t                item;
	logic                 result_valid;
	logic                 result_ready;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_BITS-1:0] cfg_data;

	histogram_bin_error_propagation_alu_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Configuration as the predictor sees it; it follows every accepted write.
	logic [31:0] factor_q;
	logic        hist_mode_a;
	logic        hist_mode_b;

	item_t   bin_queue[$];
	result_t expected_bins[$];

	int send_idle_pct;
	int recv_stall_pct;
	int error_count;
	int bins_sent;
	int bins_checked;
	int stall_cycles;
	bit stimulus_done;
	bit item_fire;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Magnitude quotient truncated toward zero; callers never pass a zero divisor.
	function automatic logic [127:0] udiv(input logic [127:0] num, input logic [127:0] den);
		return num / den;
	endfunction

	// Floored square root of a 128-bit value, settled one root bit at a time.
	function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
		logic [63:0]  root;
		logic [63:0]  trial;
		logic [127:0] square;
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			square = 128'(trial) * 128'(trial);
			if (square <= x)
				root = trial;
		end
		return root;
	endfunction

	// Clamp an unsigned magnitude to a limit and note when it was clipped.
	function automatic logic [63:0] clip(input logic [127:0] m, input logic [63:0] lim,
			inout bit sat);
		if (m > 128'(lim)) begin
			sat = 1'b1;
			return lim;
		end
		return m[63:0];
	endfunction

	// Quadrature sum of two uncertainties, clipped to the uncertainty range.
	function automatic logic [31:0] quad_sum(input logic [63:0] a, input logic [63:0] b,
			inout bit sat);
		logic [127:0] sq;
		sq = 128'(a) * 128'(a) + 128'(b) * 128'(b);
		return 32'(clip(128'(floor_sqrt(sq)), 64'hFFFF_FFFF, sat));
	endfunction

	// Expected result of one bin pair under the current configuration.
	function automatic result_t propagate_bin(input item_t it);
		result_t      r;
		logic [31:0]  ma, mb;
		logic [127:0] mag;
		logic [63:0]  t1, t2, m;
		logic [31:0]  err;
		logic         na, nb, neg, mode;
		longint       s;
		bit           sat, bad, dz;
		na = it.value_a[31];
		nb = it.value_b[31];
		ma = na ? -it.value_a : it.value_a;
		mb = nb ? -it.value_b : it.value_b;
		mode = hist_mode_a;
		mag = '0;
		err = '0;
		neg = 1'b0;
		sat = 1'b0;
		bad = 1'b0;
		dz = 1'b0;
		case (it.op)
			OP_SCALE: begin
				mag = (128'(ma) * 128'(factor_q)) >> FRAC_BITS;
				neg = na;
				err = 32'(clip((128'(it.error_a) * 128'(factor_q)) >> FRAC_BITS,
					64'hFFFF_FFFF, sat));
			end
			OP_DIVF: begin
				if (factor_q == 0) begin
					dz = 1'b1;
				end else begin
					mag = udiv(128'(ma) << FRAC_BITS, 128'(factor_q));
					neg = na;
					err = 32'(clip(udiv(128'(it.error_a) << FRAC_BITS, 128'(factor_q)),
						64'hFFFF_FFFF, sat));
				end
			end
			OP_ADD, OP_SUB: begin
				if (hist_mode_a != hist_mode_b) begin
					bad = 1'b1;
				end else begin
					s = (it.op == OP_ADD) ? longint'(it.value_a) + longint'(it.value_b)
						: longint'(it.value_a) - longint'(it.value_b);
					neg = s < 0;
					mag = 128'(neg ? -s : s);
					err = quad_sum(64'(it.error_a), 64'(it.error_b), sat);
				end
			end
			OP_MUL: begin
				if (hist_mode_a == MODE_COUNTS && hist_mode_b == MODE_COUNTS) begin
					bad = 1'b1;
				end else begin
					mode = (hist_mode_b == MODE_COUNTS) ? MODE_COUNTS : hist_mode_a;
					mag = (128'(ma) * 128'(mb)) >> FRAC_BITS;
					neg = na != nb;
					t1 = clip((128'(it.error_a) * 128'(mb)) >> FRAC_BITS, 64'hFFFF_FFFF, sat);
					t2 = clip((128'(it.error_b) * 128'(ma)) >> FRAC_BITS, 64'hFFFF_FFFF, sat);
					err = quad_sum(t1, t2, sat);
				end
			end
			OP_DIV: begin
				if (hist_mode_a == MODE_FREQ && hist_mode_b == MODE_COUNTS) begin
					bad = 1'b1;
				end else begin
					mode = (hist_mode_a == hist_mode_b) ? MODE_FREQ : hist_mode_a;
					if (mb == 0) begin
						dz = 1'b1;
					end else begin
						mag = udiv(128'(ma) << FRAC_BITS, 128'(mb));
						neg = na != nb;
						t1 = clip(udiv(128'(it.error_a) << FRAC_BITS, 128'(mb)),
							64'hFFFF_FFFF, sat);
						t2 = clip(udiv((128'(it.error_b) * 128'(ma)) << FRAC_BITS,
							128'(mb) * 128'(mb)), 64'hFFFF_FFFF, sat);
						err = quad_sum(t1, t2, sat);
					end
				end
			end
			default: bad = 1'b1;
		endcase
		r.mode_out = mode;
		if (bad) begin
			r.mode_out = hist_mode_a;
			r.status = ST_MODE;
			r.value_out = '0;
			r.error_out = '0;
		end else if (dz) begin
			r.status = ST_DIVZERO;
			r.value_out = '0;
			r.error_out = '0;
		end else begin
			if (neg) begin
				m = clip(mag, 64'h8000_0000, sat);
				r.value_out = -32'(m);
			end else begin
				r.value_out = 32'(clip(mag, 64'h7FFF_FFFF, sat));
			end
			r.error_out = err;
			r.status = sat ? ST_SAT : ST_OK;
		end
		return r;
	endfunction

	// Driver: presents queued bins at the falling edge, idling at random. A new
	// bin replaces the current one only after the last rising edge accepted it.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || item_fire) begin
				if (bin_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					item <= bin_queue.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// The handshake state is sampled just before the driver changes it, so the
	// check at the rising edge sees exactly what the block saw.
	always @(posedge clk) begin
		if (arst_n) begin
			item_fire <= item_valid && item_ready;
			if (item_valid && item_ready) begin
				expected_bins.push_back(propagate_bin(item));
				bins_sent++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SCALE:  factor_q <= cfg_data;
					CFG_MODE_A: hist_mode_a <= cfg_data[0];
					CFG_MODE_B: hist_mode_b <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// Monitor: compares each result transaction with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_bins.size() == 0) begin
				$display("%0t: result with nothing expected: got %h", $time, result);
				error_count++;
			end else begin
				want = expected_bins.pop_front();
				bins_checked++;
				if (result.value_out !== want.value_out) begin
					$display("%0t: value_out expected %h actual %h", $time,
						want.value_out, result.value_out);
					error_count++;
				end
				if (result.error_out !== want.error_out) begin
					$display("%0t: error_out expected %h actual %h", $time,
						want.error_out, result.error_out);
					error_count++;
				end
				if (result.mode_out !== want.mode_out) begin
					$display("%0t: mode_out expected %b actual %b", $time,
						want.mode_out, result.mode_out);
					error_count++;
				end
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, result.status);
					error_count++;
				end
			end
		end
	end

	// Watchdog: any accepted transaction on any of the three channels restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)
					|| (cfg_valid && cfg_ready) || stimulus_done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: watchdog expired, %0d results outstanding", $time,
					expected_bins.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return $urandom_range(3);
			1: return 32'hFFFF_FFFF - $urandom_range(3);
			2: return {1'b0, 31'h7FFF_FFFF} - $urandom_range(3);
			3: return 32'h8000_0000 + $urandom_range(3);
			4: return $urandom_range(32'h0004_0000);
			default: return $urandom();
		endcase
	endfunction

	function automatic item_t make_bin(input logic [2:0] op);
		item_t it;
		it.op = op_t'(op);
		it.value_a = rand_word();
		it.error_a = rand_word();
		it.value_b = rand_word();
		it.error_b = rand_word();
		return it;
	endfunction

	function automatic item_t fixed_bin(input logic [2:0] op, input logic [31:0] va,
			input logic [31:0] ea, input logic [31:0] vb, input logic [31:0] eb);
		item_t it;
		it.op = op_t'(op);
		it.value_a = va;
		it.error_a = ea;
		it.value_b = vb;
		it.error_b = eb;
		return it;
	endfunction

	// Write one register while the block is idle.
	task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait for every queued bin to be sent and every expected result to arrive.
	task automatic drain();
		while (bin_queue.size() > 0 || item_valid || expected_bins.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [31:0] factor, input logic ma, input logic mb,
			input int count, input int idle_pct, input int stall_pct);
		write_reg(CFG_SCALE, factor);
		write_reg(CFG_MODE_A, {31'd0, ma});
		write_reg(CFG_MODE_B, {31'd0, mb});
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < count; i++)
			bin_queue.push_back(make_bin(($urandom_range(7) < 7) ? 3'($urandom_range(5))
				: 3'($urandom_range(7))));
		drain();
	endtask

	initial begin
		logic [31:0] factors[4];
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SCALE;
		cfg_data = '0;
		factor_q = SCALE_ONE;
		hist_mode_a = MODE_COUNTS;
		hist_mode_b = MODE_COUNTS;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		error_count = 0;
		bins_sent = 0;
		bins_checked = 0;
		stall_cycles = 0;
		stimulus_done = 1'b0;
		item_fire = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed bins at reset configuration: counts with counts, so add and
		// subtract pass, multiply is rejected and divide runs.
		bin_queue.push_back(fixed_bin(OP_SCALE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0));
		bin_queue.push_back(fixed_bin(OP_SCALE, 32'h8000_0000, 0, 0, 0));
		bin_queue.push_back(fixed_bin(OP_DIVF, 32'hFFFF_0000, 32'h0001_0000, 0, 0));
		bin_queue.push_back(fixed_bin(OP_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'h0000_0001, 32'hFFFF_FFFF));
		bin_queue.push_back(fixed_bin(OP_SUB, 32'h8000_0000, 0, 32'h0000_0001, 0));
		bin_queue.push_back(fixed_bin(OP_SUB, 32'h8000_0000, 3, 32'h8000_0000, 4));
		bin_queue.push_back(fixed_bin(OP_MUL, 32'h0002_0000, 1, 32'h0003_0000, 1));
		bin_queue.push_back(fixed_bin(OP_DIV, 32'h0001_0000, 1, 0, 1));
		bin_queue.push_back(fixed_bin(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF));
		bin_queue.push_back(fixed_bin(OP_DIV, 32'hFFFE_0000, 32'h0000_8000,
			32'h0004_0000, 32'h0001_0000));
		bin_queue.push_back(fixed_bin(3'd6, 32'h1234_5678, 1, 2, 3));
		bin_queue.push_back(fixed_bin(3'd7, 32'h8765_4321, 1, 2, 3));
		drain();

		// Zero factor, frequencies times counts: divide by factor hits zero,
		// multiply runs, add is rejected.
		write_reg(CFG_SCALE, 32'd0);
		write_reg(CFG_MODE_A, {31'd0, MODE_FREQ});
		bin_queue.push_back(fixed_bin(OP_DIVF, 32'h0001_0000, 1, 0, 0));
		bin_queue.push_back(fixed_bin(OP_SCALE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0));
		bin_queue.push_back(fixed_bin(OP_MUL, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'hFFFF_FFFF));
		bin_queue.push_back(fixed_bin(OP_MUL, 32'h8000_0000, 0, 32'h0001_0000, 0));
		bin_queue.push_back(fixed_bin(OP_ADD, 1, 1, 1, 1));
		bin_queue.push_back(fixed_bin(OP_DIV, 32'h0001_0000, 1, 32'h0001_0000, 1));
		drain();

		// Random phases sweep all mode pairs, extreme factors and every idling
		// pattern.
		factors[0] = 32'd0;
		factors[1] = 32'hFFFF_FFFF;
		factors[2] = SCALE_ONE;
		factors[3] = 32'd1;
		for (int p = 0; p < 16; p++) begin
			int idle, stall;
			case (p % 4)
				0: begin idle = 0; stall = 0; end
				1: begin idle = 88; stall = 0; end
				2: begin idle = 0; stall = 88; end
				default: begin idle = 22; stall = 22; end
			endcase
			run_phase((p < 4) ? factors[p] : $urandom(), p[0], p[1] ^ p[2], 115, idle, stall);
		end

		stimulus_done = 1'b1;
		$display("Sent %0d bin pairs over 18 configuration settings, checked %0d results.",
			bins_sent, bins_checked);
		$display("All six operations, unknown codes, every mode pair and idling mix ran.");
		if (error_count == 0 && expected_bins.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
